// ===== design/pcp_pkg.sv =====
// Package for the plane closure propagator: sizes, codes, item and result types
// and the control group shared by the node cells and the line count unit.
// No dependencies.
`default_nettype none

package pcp_pkg;

  localparam int MAX_PLANES  = 64;
  localparam int MAX_LINES   = 64;
  localparam int CELL_PLANES = 8;
  localparam int NUM_CELLS   = (MAX_PLANES + CELL_PLANES - 1) / CELL_PLANES;
  localparam int NUM_SLOTS   = NUM_CELLS * CELL_PLANES;
  localparam int CNT_W       = $clog2(NUM_CELLS + 1);
  localparam int CELL_IDX_W  = (CELL_PLANES > 1) ? $clog2(CELL_PLANES) : 1;

  localparam int KIND_W   = 3;
  localparam int PLANE_W  = 6;
  localparam int MASK_W   = 64;
  localparam int STATUS_W = 2;
  localparam int CFG_W    = 7;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD    = 3'd0,
    KIND_CLEAR   = 3'd1,
    KIND_INSERT  = 3'd2,
    KIND_EXCLUDE = 3'd3,
    KIND_SELECT  = 3'd4
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE   = 2'd0,
    ST_FORBID = 2'd1,
    ST_NOFREE = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PLANE_COUNT = 1'b0,
    CFG_LINE_COUNT  = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_PROP  = 3'b010,
    S_FORCE = 3'b100
  } state_e;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [PLANE_W-1:0] plane;
    logic [MASK_W-1:0]  line_mask;
  } item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [PLANE_W-1:0]  found_plane;
    logic [MASK_W-1:0]   chosen_set;
  } result_t;

  typedef struct packed {
    logic load;
    logic clear;
    logic seed;
    logic excl;
    logic restore;
    logic advance;
    logic apply;
  } node_ctrl_t;

endpackage

`default_nettype wire

// ===== design/pcp_cell.sv =====
// One node cell: incidence rows, free/chosen/fresh bits and a backup for a
// group of planes, plus one stage of the line hit accumulation chain.
// Depends on pcp_pkg.
`default_nettype none

module pcp_cell (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  pcp_pkg::node_ctrl_t                 ctrl_i,
  input  logic [pcp_pkg::CELL_PLANES-1:0]     sel_i,
  input  logic [pcp_pkg::CELL_PLANES-1:0]     use_i,
  input  logic [pcp_pkg::MAX_LINES-1:0]       row_data_i,
  input  logic [pcp_pkg::MAX_LINES-1:0]       pushed_i,
  input  logic [pcp_pkg::MAX_LINES-1:0]       any_i,
  input  logic [pcp_pkg::MAX_LINES-1:0]       two_i,
  output logic [pcp_pkg::MAX_LINES-1:0]       any_o,
  output logic [pcp_pkg::MAX_LINES-1:0]       two_o,
  output logic [pcp_pkg::CELL_PLANES-1:0]     fr_o,
  output logic [pcp_pkg::CELL_PLANES-1:0]     ch_o,
  output logic [pcp_pkg::CELL_PLANES-1:0]     forced_o,
  output logic                                conflict_o
);
  import pcp_pkg::*;

  logic [MAX_LINES-1:0]   row_q [CELL_PLANES];
  logic [CELL_PLANES-1:0] fr_q, fr_d, ch_q, ch_d, fresh_q, fresh_d;
  logic [CELL_PLANES-1:0] bk_fr_q, bk_ch_q;
  logic [MAX_LINES-1:0]   any_q, any_d, two_q, two_d;
  logic [CELL_PLANES-1:0] forced;

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < CELL_PLANES; k++) begin
      if (ctrl_i.load && sel_i[k]) begin
        row_q[k] <= row_data_i;
      end
    end
    if (ctrl_i.seed) begin
      bk_fr_q <= fr_q;
      bk_ch_q <= ch_q;
    end
  end

  // fresh planes add their hits to the counts handed down the chain
  always_comb begin
    any_d = any_i;
    two_d = two_i;
    for (int k = 0; k < CELL_PLANES; k++) begin
      if (fresh_q[k]) begin
        two_d = two_d | (any_d & row_q[k]);
        any_d = any_d | row_q[k];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < CELL_PLANES; k++) begin
      forced[k] = use_i[k] && !ch_q[k] && (|(row_q[k] & pushed_i));
    end
  end

  always_comb begin
    fr_d    = fr_q;
    ch_d    = ch_q;
    fresh_d = fresh_q;
    if (ctrl_i.clear) begin
      fr_d    = use_i;
      ch_d    = '0;
      fresh_d = '0;
    end else if (ctrl_i.seed) begin
      fr_d    = fr_q & ~sel_i;
      ch_d    = ch_q | sel_i;
      fresh_d = sel_i;
    end else if (ctrl_i.excl) begin
      fr_d    = fr_q & ~(sel_i & use_i);
    end else if (ctrl_i.restore) begin
      fr_d    = bk_fr_q;
      ch_d    = bk_ch_q;
      fresh_d = '0;
    end else if (ctrl_i.advance) begin
      fr_d    = fr_q & ~forced;
      ch_d    = ch_q | forced;
      fresh_d = forced;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fr_q    <= '1;
      ch_q    <= '0;
      fresh_q <= '0;
      any_q   <= '0;
      two_q   <= '0;
    end else begin
      fr_q    <= fr_d;
      ch_q    <= ch_d;
      fresh_q <= fresh_d;
      any_q   <= any_d;
      two_q   <= two_d;
    end
  end

  assign any_o      = any_q;
  assign two_o      = two_q;
  assign fr_o       = fr_q;
  assign ch_o       = ch_q;
  assign forced_o   = forced;
  assign conflict_o = |(forced & ~fr_q);

endmodule

`default_nettype wire

// ===== design/pcp_lines.sv =====
// Per-line chosen-plane counts (zero, one, two or more) with a backup copy;
// turns the chain's hit vectors into the set of lines pushed to two.
// Depends on pcp_pkg.
`default_nettype none

module pcp_lines (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pcp_pkg::node_ctrl_t           ctrl_i,
  input  logic [pcp_pkg::MAX_LINES-1:0] lines_use_i,
  input  logic [pcp_pkg::MAX_LINES-1:0] any_i,
  input  logic [pcp_pkg::MAX_LINES-1:0] two_i,
  output logic [pcp_pkg::MAX_LINES-1:0] pushed_o
);
  import pcp_pkg::*;

  logic [MAX_LINES-1:0] z_q, z_d, o_q, o_d, pushed_q, pushed_d;
  logic [MAX_LINES-1:0] bk_z_q, bk_o_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.seed) begin
      bk_z_q <= z_q;
      bk_o_q <= o_q;
    end
  end

  always_comb begin
    z_d      = z_q;
    o_d      = o_q;
    pushed_d = pushed_q;
    if (ctrl_i.clear) begin
      z_d = lines_use_i;
      o_d = '0;
    end else if (ctrl_i.restore) begin
      z_d = bk_z_q;
      o_d = bk_o_q;
    end else if (ctrl_i.apply) begin
      pushed_d = (o_q & any_i) | (z_q & two_i);
      z_d      = z_q & ~any_i;
      o_d      = (o_q & ~any_i) | (z_q & any_i & ~two_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      z_q      <= '1;
      o_q      <= '0;
      pushed_q <= '0;
    end else begin
      z_q      <= z_d;
      o_q      <= o_d;
      pushed_q <= pushed_d;
    end
  end

  assign pushed_o = pushed_q;

endmodule

`default_nettype wire

// ===== design/plane_closure_propagator.sv =====
// Top level of the plane closure propagator: command decode, sequencer,
// configuration registers and the chain of node cells.
// Depends on pcp_pkg, pcp_cell and pcp_lines.
//
// Usage. An item (kind, plane, line_mask) is taken on a clock edge with
// start_i high and busy_o low. Every item gives one result on result_o,
// marked by result_valid_o for exactly one cycle; the receiver cannot stall.
// Load, clear, exclude, select, the unused kinds and inserts that need no
// propagation finish on the accepting edge: their result shows in the next
// cycle and busy_o stays low, so such items can be issued every cycle. An
// insert that must propagate raises busy_o; each propagation round walks
// the line hit vectors down the chain of NUM_CELLS cells (8 planes each)
// and then forces planes; rounds repeat while planes are forced. A failed
// insert restores the node from its backup in the same cycle it reports.
// chosen_set is read from the node while the strobe is high.
// Configuration: cfg_we_i writes cfg_data_i to the register at cfg_idx_i
// (plane count, line count); only issue writes while idle.
// Reset: counts return to 64, all planes in use free, no plane chosen,
// every line at count zero. Incidence rows hold nothing until loaded.
`default_nettype none

module plane_closure_propagator (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  pcp_pkg::item_t                    item_i,
  output logic                              result_valid_o,
  output pcp_pkg::result_t                  result_o,
  input  logic                              cfg_we_i,
  input  logic [pcp_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [pcp_pkg::CFG_W-1:0]         cfg_data_i
);
  import pcp_pkg::*;

  state_e               state_q, state_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [CFG_W-1:0]     pc_q, lc_q;
  logic                 res_valid_q, res_valid_d;
  logic [STATUS_W-1:0]  status_q, status_d;
  logic [PLANE_W-1:0]   found_q, found_d;

  node_ctrl_t           ctrl;
  logic                 accept;
  logic [NUM_SLOTS-1:0] use_all, sel_all, fr_all, ch_all, forced_all, avail;
  logic [MAX_LINES-1:0] lines_use, pushed;
  logic [NUM_CELLS-1:0] conflict_w;
  logic                 p_use, p_fr, p_ch;

  logic [MAX_LINES-1:0]   any_w [NUM_CELLS];
  logic [MAX_LINES-1:0]   two_w [NUM_CELLS];
  logic [CELL_PLANES-1:0] fr_w [NUM_CELLS];
  logic [CELL_PLANES-1:0] ch_w [NUM_CELLS];
  logic [CELL_PLANES-1:0] forced_w [NUM_CELLS];

  logic [NUM_CELLS-1:0]  grp_has;
  logic [CELL_IDX_W-1:0] grp_idx [NUM_CELLS];
  logic [PLANE_W-1:0]    first_free;

  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      use_all[i] = (i < MAX_PLANES) && (CFG_W'(i) < pc_q);
      sel_all[i] = (i < MAX_PLANES) && (item_i.plane == PLANE_W'(i));
    end
    for (int l = 0; l < MAX_LINES; l++) begin
      lines_use[l] = (CFG_W'(l) < lc_q);
    end
  end

  for (genvar c = 0; c < NUM_CELLS; c++) begin : g_cell
    logic [MAX_LINES-1:0] any_in, two_in;
    if (c == 0) begin : g_head
      assign any_in = '0;
      assign two_in = '0;
    end else begin : g_link
      assign any_in = any_w[c-1];
      assign two_in = two_w[c-1];
    end

    pcp_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .sel_i      (sel_all[c*CELL_PLANES +: CELL_PLANES]),
      .use_i      (use_all[c*CELL_PLANES +: CELL_PLANES]),
      .row_data_i (item_i.line_mask[MAX_LINES-1:0]),
      .pushed_i   (pushed),
      .any_i      (any_in),
      .two_i      (two_in),
      .any_o      (any_w[c]),
      .two_o      (two_w[c]),
      .fr_o       (fr_w[c]),
      .ch_o       (ch_w[c]),
      .forced_o   (forced_w[c]),
      .conflict_o (conflict_w[c])
    );

    assign fr_all[c*CELL_PLANES +: CELL_PLANES]     = fr_w[c];
    assign ch_all[c*CELL_PLANES +: CELL_PLANES]     = ch_w[c];
    assign forced_all[c*CELL_PLANES +: CELL_PLANES] = forced_w[c];
  end

  pcp_lines u_lines (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .lines_use_i (lines_use),
    .any_i       (any_w[NUM_CELLS-1]),
    .two_i       (two_w[NUM_CELLS-1]),
    .pushed_o    (pushed)
  );

  // first free plane: per group, then across groups; lowest index wins
  assign avail = fr_all & use_all;
  always_comb begin
    first_free = '0;
    for (int g = 0; g < NUM_CELLS; g++) begin
      grp_has[g] = 1'b0;
      grp_idx[g] = '0;
      for (int k = CELL_PLANES - 1; k >= 0; k--) begin
        if (avail[g*CELL_PLANES + k]) begin
          grp_has[g] = 1'b1;
          grp_idx[g] = CELL_IDX_W'(k);
        end
      end
    end
    for (int g = NUM_CELLS - 1; g >= 0; g--) begin
      if (grp_has[g]) begin
        first_free = PLANE_W'(g * CELL_PLANES + int'(grp_idx[g]));
      end
    end
  end

  assign p_use  = |(sel_all & use_all);
  assign p_fr   = |(sel_all & fr_all);
  assign p_ch   = |(sel_all & ch_all);
  assign accept = start_i && (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    res_valid_d = 1'b0;
    status_d    = ST_DONE;
    found_d     = '0;
    ctrl        = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_valid_d = 1'b1;
          case (item_i.kind)
            KIND_LOAD:    ctrl.load  = 1'b1;
            KIND_CLEAR:   ctrl.clear = 1'b1;
            KIND_EXCLUDE: ctrl.excl  = 1'b1;
            KIND_SELECT: begin
              if (|avail) begin
                found_d = first_free;
              end else begin
                status_d = ST_NOFREE;
              end
            end
            KIND_INSERT: begin
              if (p_use && !p_ch) begin
                if (!p_fr) begin
                  status_d = ST_FORBID;
                end else begin
                  ctrl.seed   = 1'b1;
                  res_valid_d = 1'b0;
                  cnt_d       = '0;
                  state_d     = S_PROP;
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_PROP: begin
        if (cnt_q == CNT_W'(NUM_CELLS)) begin
          ctrl.apply = 1'b1;
          state_d    = S_FORCE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_FORCE: begin
        if (|conflict_w) begin
          ctrl.restore = 1'b1;
          status_d     = ST_FORBID;
          res_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end else begin
          ctrl.advance = 1'b1;
          if (|forced_all) begin
            cnt_d   = '0;
            state_d = S_PROP;
          end else begin
            res_valid_d = 1'b1;
            state_d     = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
      pc_q        <= CFG_RESET;
      lc_q        <= CFG_RESET;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      res_valid_q <= res_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_PLANE_COUNT: pc_q <= cfg_data_i;
          CFG_LINE_COUNT:  lc_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    found_q  <= found_d;
  end

  assign busy_o                = (state_q != S_IDLE);
  assign result_valid_o        = res_valid_q;
  assign result_o.status       = status_q;
  assign result_o.found_plane  = found_q;
  assign result_o.chosen_set   = MASK_W'(ch_all[MAX_PLANES-1:0]);

endmodule

`default_nettype wire
